@@ src/small_16bit_cpu_core_unit_assert.svh @@
// Assertion macros for the small CPU core; both expect clk in scope, and S16C_ASSERT also rst.
`ifndef SMALL_16BIT_CPU_CORE_UNIT_ASSERT_SVH
`define SMALL_16BIT_CPU_CORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define S16C_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("s16c assertion failed");
`define S16C_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("s16c assertion failed");
`else
`define S16C_ASSERT(lbl, prop)
`define S16C_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ src/s16c_pkg.sv @@
package s16c_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_NOP   = 5'd0;
  localparam op_t OP_HALT  = 5'd3;
  localparam op_t OP_RCSR  = 5'd4;
  localparam op_t OP_MOVE  = 5'd6;
  localparam op_t OP_JUMP  = 5'd8;
  localparam op_t OP_IMM   = 5'd9;
  localparam op_t OP_CALL  = 5'd10;
  localparam op_t OP_IMM2  = 5'd11;
  localparam op_t OP_LOAD  = 5'd12;
  localparam op_t OP_STORE = 5'd13;
  localparam op_t OP_ADD   = 5'd16;
  localparam op_t OP_SUB   = 5'd17;
  localparam op_t OP_XOR   = 5'd20;
  localparam op_t OP_AND   = 5'd21;
  localparam op_t OP_OR    = 5'd22;
  localparam op_t OP_SHL   = 5'd23;
  localparam op_t OP_SHR   = 5'd24;
  localparam op_t OP_ASR   = 5'd25;
  localparam op_t OP_IFEQ  = 5'd26;
  localparam op_t OP_IFNE  = 5'd27;
  localparam op_t OP_IFLT  = 5'd28;
  localparam op_t OP_IFGE  = 5'd29;
  localparam op_t OP_IFULT = 5'd30;
  localparam op_t OP_IFUGE = 5'd31;

  typedef logic [1:0] req_t;
  localparam req_t REQ_PROG = 2'd0;
  localparam req_t REQ_DATA = 2'd1;
  localparam req_t REQ_EXEC = 2'd2;
  localparam req_t REQ_NONE = 2'd3;

  localparam logic [15:0] PORT_ADDR = 16'hFF00;
  localparam logic [15:0] HOLE_ADDR = 16'hFFFF;

  typedef struct packed {
    logic        is_rr;
    op_t         op;
    logic [3:0]  rd;
    logic [3:0]  rs;
    logic [15:0] imm;
  } dec_t;

  function automatic dec_t decode_word(logic [15:0] w);
    dec_t d;
    d.is_rr = 1'b0;
    d.op    = OP_NOP;
    d.rd    = w[15:12];
    d.rs    = 4'd0;
    d.imm   = 16'd0;
    unique case (w[1:0])
      2'b00: begin
        d.is_rr = 1'b1;
        d.op    = w[6:2];
        d.rs    = w[11:8];
      end
      2'b10: begin
        d.op  = {3'b011, w[3:2]};
        d.rs  = w[11:8];
        d.imm = {12'd0, w[7:4]};
      end
      2'b11: begin
        d.op  = {1'b1, w[5:2]};
        d.imm = {{10{w[11]}}, w[11:6]};
      end
      2'b01: begin
        if (!w[2]) begin
          d.op  = {4'b0011, w[3]};
          d.imm = {{8{w[11]}}, w[11:4]};
        end else if (!w[3]) begin
          d.rd  = 4'd0;
          d.op  = {3'b010, w[4:3]};
          d.imm = {{5{w[15]}}, w[15:5]};
        end else begin
          d.rd  = 4'd0;
          d.op  = OP_IMM;
          d.imm = {{4{w[15]}}, w[15:4]};
        end
      end
    endcase
    return d;
  endfunction

endpackage

@@ src/s16c_req_if.sv @@
interface s16c_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] addr;
  logic [15:0] wdata;

  modport source (output valid, req_type, addr, wdata, input ready);
  modport sink (input valid, req_type, addr, wdata, output ready);
endinterface

@@ src/s16c_rsp_if.sv @@
interface s16c_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_pc;
  logic        halted;
  logic        faulted;
  logic        char_valid;
  logic [7:0]  char_byte;
  logic [15:0] status_word;

  modport source (output valid, step_pc, halted, faulted, char_valid, char_byte,
                  status_word, input ready);
  modport sink (input valid, step_pc, halted, faulted, char_valid, char_byte,
                status_word, output ready);
endinterface

@@ src/small_16bit_cpu_core_unit.sv @@
// Small 16-bit CPU core with prefix immediates.
// Channel req (valid/ready) carries one transaction per request: req_type 0
// writes a program word, 1 writes a data word through the bus map (0xFF00 is
// the character port, 0xFFFF is unmapped), 2 executes one instruction at pc.
// Channel rsp returns exactly one transaction per request, in order: pc,
// sticky halt/fault flags, the character stored this step and register r1.
// Pipeline: A (accept, program fetch at pc and pc+1), D (decode, register
// reads), X (execute, write back, data access), M (load write back only).
// The result is registered in the output register after X, or after M for
// a load. A new transaction is taken in the X cycle of the previous one, or
// in its M cycle for a load, as that one retires. Reset clears pc, flags,
// prefix and registers at once, then runs a clearing pass over all
// PROG_WORDS program memory words with ready held low. Data memory holds
// garbage until written. When rsp stalls, one result waits in the output
// register; the next transaction is still taken but holds in X, or in M for
// a load.
`include "small_16bit_cpu_core_unit_assert.svh"

module small_16bit_cpu_core_unit import s16c_pkg::*; #(
  parameter int PROG_WORDS = 65536,
  parameter int DATA_WORDS = 65536
) (
  input  logic    clk,
  input  logic    rst,
  s16c_req_if.sink   req,
  s16c_rsp_if.source rsp
);

  localparam int PA = $clog2(PROG_WORDS);
  localparam int DA = $clog2(DATA_WORDS);

  // architectural state outside memories
  logic [15:0] pc;
  logic        halted;
  logic        faulted;
  logic        pre_v;
  logic [15:0] pre_val;
  logic [15:0] r1;

  // program memory clearing pass
  logic          clearing;
  logic [PA-1:0] clr_idx;

  // pipeline control
  logic d_v, x_v, m_v, o_v;
  logic in_acc, in_ready, slot_free, x_fire, m_fire, x_ld;

  // stage payloads
  req_t        d_req, x_req;
  logic [15:0] d_addr, d_wdata, x_addr, x_wdata;
  logic [15:0] f_w0, f_w1;
  logic        f_oor0, f_oor1;
  dec_t        dd, x_dec;
  logic        d_nw_imm, x_nw_imm;
  logic [15:0] w0, w1;

  // memories
  logic [15:0] prog_mem [PROG_WORDS];
  logic [15:0] data_mem [DATA_WORDS];
  logic [15:0] rf_mem [16];
  logic [15:0] rf_vld;
  logic [15:0] ra_q, rb_q, dm_q;
  logic        ra_vq, rb_vq;

  // execute results
  logic [15:0] a, b, fpc, fpc1;
  logic [15:0] n_pc, n_pre_val;
  logic        n_halt, n_fault, n_pre_v;
  logic        x_we;
  logic [3:0]  x_wa;
  logic [15:0] x_wd;
  logic        dm_we;
  logic [15:0] dm_addr, ld_addr;
  logic [15:0] dm_data;
  logic        ch_v;
  logic [7:0]  ch_b;
  logic        ld_zero;

  // load stage
  logic [3:0]  m_rd;
  logic        m_zero;
  logic [15:0] m_val;

  // write back mux
  logic        rf_we;
  logic [3:0]  rf_wa;
  logic [15:0] rf_wd;

  // output register
  logic [15:0] o_pc, o_st;
  logic        o_halt, o_fault, o_cv;
  logic [7:0]  o_cb;

  function automatic logic in_prog(logic [15:0] x);
    return {1'b0, x} < 17'(PROG_WORDS);
  endfunction

  function automatic logic in_data(logic [15:0] x);
    return {1'b0, x} < 17'(DATA_WORDS);
  endfunction

  // ---------------------------------------------------------------- control
  assign slot_free = !o_v || rsp.ready;
  assign x_fire    = x_v && (x_ld || slot_free);
  assign m_fire    = m_v && slot_free;
  // take the next transaction while the current one retires from X or M
  assign in_ready  = !clearing && !d_v && (!x_v || (x_fire && !x_ld)) && (!m_v || m_fire);
  assign req.ready = in_ready;
  assign in_acc    = req.valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
      d_v      <= 1'b0;
      x_v      <= 1'b0;
      m_v      <= 1'b0;
      o_v      <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_idx == PA'(PROG_WORDS - 1)) begin
          clearing <= 1'b0;
        end
        clr_idx <= clr_idx + 1'b1;
      end
      d_v <= in_acc;
      if (d_v) begin
        x_v <= 1'b1;
      end else if (x_fire) begin
        x_v <= 1'b0;
      end
      if (x_fire && x_ld) begin
        m_v <= 1'b1;
      end else if (m_fire) begin
        m_v <= 1'b0;
      end
      if ((x_fire && !x_ld) || m_fire) begin
        o_v <= 1'b1;
      end else if (rsp.ready) begin
        o_v <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- A: program fetch
  // forward the pc of the retiring instruction to the fetch
  assign fpc  = x_v ? n_pc : pc;
  assign fpc1 = fpc + 16'd1;

  always_ff @(posedge clk) begin
    if (clearing) begin
      prog_mem[clr_idx] <= '0;
    end else if (in_acc && req.req_type == REQ_PROG && in_prog(req.addr)) begin
      prog_mem[req.addr[PA-1:0]] <= req.wdata;
    end
    if (in_acc) begin
      f_w0    <= prog_mem[fpc[PA-1:0]];
      f_w1    <= prog_mem[fpc1[PA-1:0]];
      f_oor0  <= !in_prog(fpc);
      f_oor1  <= !in_prog(fpc1);
      d_req   <= req.req_type;
      d_addr  <= req.addr;
      d_wdata <= req.wdata;
    end
  end

  // ------------------------------------------------- D: decode, reg reads
  assign w0       = f_oor0 ? 16'd0 : f_w0;
  assign w1       = f_oor1 ? 16'd0 : f_w1;
  assign dd       = decode_word(w0);
  assign d_nw_imm = (decode_word(w1).op == OP_IMM);

  always_ff @(posedge clk) begin
    if (d_v) begin
      ra_q     <= rf_mem[dd.rd];
      rb_q     <= rf_mem[dd.rs];
      x_dec    <= dd;
      x_nw_imm <= d_nw_imm;
      x_req    <= d_req;
      x_addr   <= d_addr;
      x_wdata  <= d_wdata;
    end
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
  end

  // registers never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
      ra_vq  <= 1'b0;
      rb_vq  <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_vld[rf_wa] <= 1'b1;
      end
      if (d_v) begin
        ra_vq <= rf_vld[dd.rd];
        rb_vq <= rf_vld[dd.rs];
      end
    end
  end

  assign a = ra_vq ? ra_q : 16'd0;
  assign b = rb_vq ? rb_q : 16'd0;

  // ------------------------------------------------------------ X: execute
  always_comb begin
    logic        exec, stop, keep, skip, bw_en;
    logic [15:0] eff, opv, base, bw_addr, bw_val;
    logic [1:0]  adv;
    exec      = (x_req == REQ_EXEC) && !halted && !faulted;
    stop      = 1'b0;
    keep      = 1'b0;
    skip      = 1'b0;
    bw_en     = 1'b0;
    adv       = 2'd0;
    bw_addr   = x_addr;
    bw_val    = x_wdata;
    eff       = pre_v ? (pre_val | {12'd0, x_dec.imm[3:0]}) : x_dec.imm;
    opv       = x_dec.is_rr ? b : eff;
    base      = pc;
    ld_addr   = b + eff;
    n_pc      = pc;
    n_halt    = halted;
    n_fault   = faulted;
    n_pre_v   = pre_v;
    n_pre_val = pre_val;
    x_we      = 1'b0;
    x_wa      = x_dec.rd;
    x_wd      = opv;
    x_ld      = 1'b0;
    if (x_req == REQ_DATA) begin
      bw_en = 1'b1;
    end
    if (exec) begin
      case (x_dec.op) inside
        OP_NOP: ;
        OP_HALT: begin
          n_halt = 1'b1;
          stop   = 1'b1;
        end
        OP_RCSR: base = a;
        OP_MOVE: x_we = 1'b1;
        OP_IMM, OP_IMM2: begin
          n_pre_val = {opv[11:0], 4'd0};
          n_pre_v   = 1'b1;
          keep      = 1'b1;
        end
        OP_JUMP, OP_CALL: begin
          if (x_dec.op == OP_CALL) begin
            x_we = 1'b1;
            x_wa = 4'd0;
            x_wd = pc;
          end
          // an indirect call through r0 lands on the link it just wrote
          if (x_dec.is_rr) begin
            base = (x_dec.op == OP_CALL && x_dec.rs == 4'd0) ? pc : b;
          end else begin
            base = pc + eff;
          end
        end
        OP_LOAD: x_ld = 1'b1;
        OP_STORE: begin
          bw_en   = 1'b1;
          bw_addr = ld_addr;
          bw_val  = a;
        end
        OP_ADD: begin x_we = 1'b1; x_wd = a + opv; end
        OP_SUB: begin x_we = 1'b1; x_wd = a - opv; end
        OP_XOR: begin x_we = 1'b1; x_wd = a ^ opv; end
        OP_AND: begin x_we = 1'b1; x_wd = a & opv; end
        OP_OR:  begin x_we = 1'b1; x_wd = a | opv; end
        OP_SHL: begin x_we = 1'b1; x_wd = a << opv[3:0]; end
        OP_SHR: begin x_we = 1'b1; x_wd = a >> opv[3:0]; end
        OP_ASR: begin x_we = 1'b1; x_wd = $signed(a) >>> opv[3:0]; end
        OP_IFEQ:  skip = (a != opv);
        OP_IFNE:  skip = (a == opv);
        OP_IFLT:  skip = !($signed(a) < $signed(opv));
        OP_IFGE:  skip = ($signed(a) < $signed(opv));
        OP_IFULT: skip = (a >= opv);
        OP_IFUGE: skip = (a < opv);
        default: begin
          // ERROR and every unimplemented opcode
          n_fault = 1'b1;
          stop    = 1'b1;
        end
      endcase
      if (!stop) begin
        // a skip also passes over an IMM prefix that follows
        adv  = skip ? (x_nw_imm ? 2'd2 : 2'd1) : 2'd0;
        n_pc = base + 16'd1 + {14'd0, adv};
        if (!keep) begin
          n_pre_v   = 1'b0;
          n_pre_val = 16'd0;
        end
      end
    end
    // bus map for stores and data writes
    ch_v    = bw_en && (bw_addr == PORT_ADDR);
    ch_b    = ch_v ? bw_val[7:0] : 8'd0;
    dm_we   = bw_en && !ch_v && (bw_addr != HOLE_ADDR) && in_data(bw_addr);
    dm_addr = bw_addr;
    dm_data = bw_val;
    ld_zero = (ld_addr == HOLE_ADDR) || !in_data(ld_addr);
  end

  always_ff @(posedge clk) begin
    if (x_fire && dm_we) begin
      data_mem[dm_addr[DA-1:0]] <= dm_data;
    end
    if (x_fire && x_ld) begin
      dm_q   <= data_mem[ld_addr[DA-1:0]];
      m_zero <= ld_zero;
      m_rd   <= x_dec.rd;
    end
  end

  // ---------------------------------------------------- M: load write back
  assign m_val = m_zero ? 16'd0 : dm_q;

  assign rf_we = m_fire || (x_fire && x_we);
  assign rf_wa = m_fire ? m_rd : x_wa;
  assign rf_wd = m_fire ? m_val : x_wd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= 16'd0;
      halted  <= 1'b0;
      faulted <= 1'b0;
      pre_v   <= 1'b0;
      pre_val <= 16'd0;
      r1      <= 16'd0;
    end else begin
      if (x_fire) begin
        pc      <= n_pc;
        halted  <= n_halt;
        faulted <= n_fault;
        pre_v   <= n_pre_v;
        pre_val <= n_pre_val;
      end
      if (rf_we && rf_wa == 4'd1) begin
        r1 <= rf_wd;
      end
    end
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (m_fire) begin
      o_pc    <= pc;
      o_halt  <= halted;
      o_fault <= faulted;
      o_cv    <= 1'b0;
      o_cb    <= 8'd0;
      o_st    <= (m_rd == 4'd1) ? m_val : r1;
    end else if (x_fire && !x_ld) begin
      o_pc    <= n_pc;
      o_halt  <= n_halt;
      o_fault <= n_fault;
      o_cv    <= ch_v;
      o_cb    <= ch_b;
      o_st    <= (x_we && x_wa == 4'd1) ? x_wd : r1;
    end
  end

  assign rsp.valid       = o_v;
  assign rsp.step_pc     = o_pc;
  assign rsp.halted      = o_halt;
  assign rsp.faulted     = o_fault;
  assign rsp.char_valid  = o_cv;
  assign rsp.char_byte   = o_cb;
  assign rsp.status_word = o_st;

  // ------------------------------------------------------------- assertions
  `S16C_ASSERT(a_x_m_excl, !(x_v && m_v))
  `S16C_ASSERT(a_halt_sticky, halted |=> halted)
  `S16C_ASSERT(a_pc_frozen, (halted || faulted) |=> $stable(pc))
  `S16C_ASSERT_ALWAYS(a_no_accept_clear, clearing |-> !req.ready)

endmodule
